[rtl/core/rbfh_pkg.sv]
// Shared types, constants and helpers for the ray/box face crossing core.
package rbfh_pkg;

  localparam int COORD_W        = 20;
  localparam int AXIS_W         = 16;
  localparam int AXIS_FRAC_BITS = 14;
  localparam int FRAC_BITS      = 16;
  localparam int FRAC_W         = FRAC_BITS + 1;
  localparam int NUM_FACES      = 6;
  localparam int DIV_W          = 38;
  localparam int DIV_STEPS      = FRAC_W;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 60;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_X  = 3'd0,
    CFG_AXIS_Y  = 3'd1,
    CFG_AXIS_Z  = 3'd2,
    CFG_CENTER  = 3'd3,
    CFG_EXTENTS = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] span_x;
    logic signed [COORD_W-1:0] span_y;
    logic signed [COORD_W-1:0] span_z;
  } item_t;

  typedef struct packed {
    logic                      hit_valid;
    logic [2:0]                face_index;
    logic [FRAC_W-1:0]         fraction;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
    logic signed [AXIS_W-1:0]  normal_x;
    logic signed [AXIS_W-1:0]  normal_y;
    logic signed [AXIS_W-1:0]  normal_z;
    logic signed [COORD_W-1:0] pen_depth;
    logic                      last_result;
  } result_t;

  // Clamp a wide signed value to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd524287;
    lo = -40'sd524288;
    if (v > hi) begin
      sat_coord = COORD_W'(hi);
    end else if (v < lo) begin
      sat_coord = COORD_W'(lo);
    end else begin
      sat_coord = COORD_W'(v);
    end
  endfunction

  // Negate an axis component; the most negative code maps to the max
  function automatic logic signed [AXIS_W-1:0] neg_axis(input logic signed [AXIS_W-1:0] v);
    if (v == {1'b1, {(AXIS_W-1){1'b0}}}) begin
      neg_axis = {1'b0, {(AXIS_W-1){1'b1}}};
    end else begin
      neg_axis = -v;
    end
  endfunction

endpackage

[rtl/core/rbfh_div.sv]
// Pipelined restoring divider: quotient of num * 2^16 / den for num <= den.
module rbfh_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [rbfh_pkg::DIV_W-1:0]      num,
  input  logic [rbfh_pkg::DIV_W-1:0]      den,
  output logic [rbfh_pkg::FRAC_W-1:0]     quo
);

  logic [rbfh_pkg::DIV_W-1:0]  rem [rbfh_pkg::DIV_STEPS-1];
  logic [rbfh_pkg::DIV_W-1:0]  dvs [rbfh_pkg::DIV_STEPS-1];
  logic [rbfh_pkg::FRAC_W-1:0] qt  [rbfh_pkg::DIV_STEPS];

  // One quotient bit per stage, MSB first
  for (genvar j = 0; j < rbfh_pkg::DIV_STEPS; j++) begin : g_step
    logic [rbfh_pkg::DIV_W:0]    trial;
    logic [rbfh_pkg::DIV_W-1:0]  den_in;
    logic [rbfh_pkg::FRAC_W-1:0] q_in;
    logic                        take;

    if (j == 0) begin : g_first
      assign trial  = {1'b0, num};
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign trial  = {rem[j-1], 1'b0};
      assign den_in = dvs[j-1];
      assign q_in   = qt[j-1];
    end

    assign take = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        qt[j] <= {q_in[rbfh_pkg::FRAC_W-2:0], take};
      end
    end

    if (j < rbfh_pkg::DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= take ? rbfh_pkg::DIV_W'(trial - {1'b0, den_in})
                         : trial[rbfh_pkg::DIV_W-1:0];
          dvs[j] <= den_in;
        end
      end
    end
  end

  assign quo = qt[rbfh_pkg::DIV_STEPS-1];

endmodule

[rtl/core/ray_box_face_hits_core.sv]
// Top level: segment against configured oriented box, two nearest face crossings.
//
// One segment is taken per cycle whenever busy is low. Results come out after the item
// has passed the 17-stage divider that forms each face's crossing fraction plus eleven
// stages of products, sums and selection. Each item gives one result (a miss, or a
// single crossing) or two; a result is shown for exactly one cycle with result_valid
// high. For an item with two crossings the whole pipeline holds while the first result
// is shown, with busy high, and moves on as the second is shown. Configuration is
// taken through cfg_valid/cfg_ready at any time; write it only while no item is in
// flight.
module ray_box_face_hits_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  rbfh_pkg::item_t                   item,
  output logic                              result_valid,
  output rbfh_pkg::result_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rbfh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbfh_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NF = rbfh_pkg::NUM_FACES;
  localparam int DS = rbfh_pkg::DIV_STEPS;
  localparam int FW = rbfh_pkg::FRAC_W;

  // Configuration registers
  logic [47:0] axis_row [3];
  logic [59:0] center;
  logic [59:0] extents;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_row[0] <= 48'd16384;
      axis_row[1] <= 48'd16384 << 16;
      axis_row[2] <= 48'd16384 << 32;
      center      <= '0;
      extents     <= {20'd1024, 20'd1024, 20'd1024};
    end else if (cfg_valid) begin
      case (rbfh_pkg::cfg_idx_t'(cfg_index))
        rbfh_pkg::CFG_AXIS_X:  axis_row[0] <= cfg_data[47:0];
        rbfh_pkg::CFG_AXIS_Y:  axis_row[1] <= cfg_data[47:0];
        rbfh_pkg::CFG_AXIS_Z:  axis_row[2] <= cfg_data[47:0];
        rbfh_pkg::CFG_CENTER:  center      <= cfg_data;
        rbfh_pkg::CFG_EXTENTS: extents     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpacked views of the configuration
  logic signed [15:0] nm [3][3];
  logic signed [19:0] ctr [3];
  logic [19:0]        ext_v [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        nm[a][k] = $signed(axis_row[a][16*k +: 16]);
      end
      ctr[a]   = $signed(center[20*a +: 20]);
      ext_v[a] = extents[20*a +: 20];
    end
  end

  // Pipeline hold while the first of two results is shown
  logic phase;
  logic k_vld;
  logic k_two;
  logic en;

  assign busy = k_vld && k_two && !phase;
  assign en   = !busy;

  // Stage A: item register
  logic               a_vld;
  logic signed [19:0] a_org [3];
  logic signed [19:0] a_spn [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_org[0] <= item.origin_x;
      a_org[1] <= item.origin_y;
      a_org[2] <= item.origin_z;
      a_spn[0] <= item.span_x;
      a_spn[1] <= item.span_y;
      a_spn[2] <= item.span_z;
    end
  end

  // Stage B: offset from center and axis products
  logic signed [20:0] b_pos [3];
  logic               b_vld;
  logic signed [19:0] b_org [3];
  logic signed [19:0] b_spn [3];
  logic signed [35:0] b_pd [3][3];
  logic signed [36:0] b_pp [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      b_pos[k] = 21'(a_org[k]) - 21'(ctr[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          b_pd[a][k] <= 36'(nm[a][k]) * 36'(a_spn[k]);
          b_pp[a][k] <= 37'(nm[a][k]) * 37'(b_pos[k]);
        end
      end
      b_org <= a_org;
      b_spn <= a_spn;
    end
  end

  // Stage C: dot products along each axis
  logic               c_vld;
  logic signed [19:0] c_org [3];
  logic signed [19:0] c_spn [3];
  logic signed [37:0] c_dsum [3];
  logic signed [38:0] c_psum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        c_dsum[a] <= 38'(b_pd[a][0]) + 38'(b_pd[a][1]) + 38'(b_pd[a][2]);
        c_psum[a] <= 39'(b_pp[a][0]) + 39'(b_pp[a][1]) + 39'(b_pp[a][2]);
      end
      c_org <= b_org;
      c_spn <= b_spn;
    end
  end

  // Stage D: per-face numerator, sign fold and range test
  logic [37:0]        d_num_next [NF];
  logic [37:0]        d_den_next [NF];
  logic [NF-1:0]      d_ok_next;
  logic               d_vld;
  logic [37:0]        d_num [NF];
  logic [37:0]        d_den [NF];

  always_comb begin
    int                 ax;
    logic signed [34:0] e;
    logic signed [39:0] num;
    logic signed [39:0] numn;
    logic signed [37:0] dabs;
    logic               neg;
    for (int i = 0; i < NF; i++) begin
      ax   = (i < 3) ? i : i - 3;
      e    = $signed({1'b0, ext_v[ax], {rbfh_pkg::AXIS_FRAC_BITS{1'b0}}});
      num  = (i < 3) ? 40'(e) : -40'(e);
      num  = num - 40'(c_psum[ax]);
      neg  = c_dsum[ax][37];
      dabs = neg ? -c_dsum[ax] : c_dsum[ax];
      numn = neg ? -num : num;
      d_ok_next[i]  = (c_dsum[ax] != '0) && !numn[39] && (numn <= 40'(dabs));
      d_num_next[i] = numn[37:0];
      d_den_next[i] = dabs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= c_vld;
    end
  end

  // Divider sideband line, aligned with the divider stages
  logic               sd_vld  [DS];
  logic signed [19:0] sd_org  [DS][3];
  logic signed [19:0] sd_spn  [DS][3];
  logic signed [37:0] sd_dsum [DS][3];
  logic signed [38:0] sd_psum [DS][3];
  logic [NF-1:0]      sd_ok   [DS];

  always_ff @(posedge clk) begin
    if (en) begin
      d_num <= d_num_next;
      d_den <= d_den_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DS; j++) begin
        sd_vld[j] <= 1'b0;
      end
    end else if (en) begin
      sd_vld[0] <= d_vld;
      for (int j = 1; j < DS; j++) begin
        sd_vld[j] <= sd_vld[j-1];
      end
    end
  end

  // Face validity joins the sideband at the divider input
  logic [NF-1:0] d_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      d_ok <= d_ok_next;
    end
  end

  logic signed [19:0] d_org [3];
  logic signed [19:0] d_spn [3];
  logic signed [37:0] d_dsum [3];
  logic signed [38:0] d_psum [3];

  always_ff @(posedge clk) begin
    if (en) begin
      d_org  <= c_org;
      d_spn  <= c_spn;
      d_dsum <= c_dsum;
      d_psum <= c_psum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_org[0]  <= d_org;
      sd_spn[0]  <= d_spn;
      sd_dsum[0] <= d_dsum;
      sd_psum[0] <= d_psum;
      sd_ok[0]   <= d_ok;
      for (int j = 1; j < DS; j++) begin
        sd_org[j]  <= sd_org[j-1];
        sd_spn[j]  <= sd_spn[j-1];
        sd_dsum[j] <= sd_dsum[j-1];
        sd_psum[j] <= sd_psum[j-1];
        sd_ok[j]   <= sd_ok[j-1];
      end
    end
  end

  // Six crossing fractions
  logic [FW-1:0] q_fr [NF];

  for (genvar i = 0; i < NF; i++) begin : g_div
    rbfh_div u_div (
      .clk (clk),
      .en  (en),
      .num (d_num[i]),
      .den (d_den[i]),
      .quo (q_fr[i])
    );
  end

  // Stage E: axis offsets scaled by each fraction
  logic               e_vld;
  logic [FW-1:0]      e_fr [NF];
  logic [NF-1:0]      e_ok;
  logic signed [19:0] e_org [3];
  logic signed [19:0] e_spn [3];
  logic signed [38:0] e_psum [3];
  logic signed [55:0] e_lp [NF][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= sd_vld[DS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NF; i++) begin
        for (int a = 0; a < 3; a++) begin
          e_lp[i][a] <= 56'(sd_dsum[DS-1][a]) * 56'($signed({1'b0, q_fr[i]}));
        end
      end
      e_fr   <= q_fr;
      e_ok   <= sd_ok[DS-1];
      e_org  <= sd_org[DS-1];
      e_spn  <= sd_spn[DS-1];
      e_psum <= sd_psum[DS-1];
    end
  end

  // Stage F: local box coordinates of each crossing
  logic               f_vld;
  logic [FW-1:0]      f_fr [NF];
  logic [NF-1:0]      f_ok;
  logic signed [19:0] f_org [3];
  logic signed [19:0] f_spn [3];
  logic signed [56:0] f_loc [NF][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NF; i++) begin
        for (int a = 0; a < 3; a++) begin
          f_loc[i][a] <= 57'($signed({e_psum[a], {rbfh_pkg::FRAC_BITS{1'b0}}}))
                       + 57'(e_lp[i][a]);
        end
      end
      f_fr  <= e_fr;
      f_ok  <= e_ok;
      f_org <= e_org;
      f_spn <= e_spn;
    end
  end

  // Stage G: inside test with 1.01 tolerance on every axis
  logic [NF-1:0]      g_hit_next;
  logic               g_vld;
  logic [NF-1:0]      g_hit;
  logic [FW-1:0]      g_fr [NF];
  logic signed [19:0] g_org [3];
  logic signed [19:0] g_spn [3];

  always_comb begin
    logic [56:0] mag;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic        h;
    for (int i = 0; i < NF; i++) begin
      h = f_ok[i];
      for (int a = 0; a < 3; a++) begin
        mag = f_loc[i][a][56] ? 57'(-f_loc[i][a]) : 57'(f_loc[i][a]);
        lhs = 64'(mag) * 64'd100;
        rhs = (64'(ext_v[a]) * 64'd101) << (rbfh_pkg::FRAC_BITS + rbfh_pkg::AXIS_FRAC_BITS);
        if (ext_v[a] == '0 || lhs > rhs) begin
          h = 1'b0;
        end
      end
      g_hit_next[i] = h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_hit <= g_hit_next;
      g_fr  <= f_fr;
      g_org <= f_org;
      g_spn <= f_spn;
    end
  end

  // Stage H: keep the two nearest, later face wins ties
  logic [2:0]         h_c_next;
  logic [2:0]         h_f_next;
  logic [FW-1:0]      h_ct_next;
  logic [FW-1:0]      h_ft_next;
  logic [1:0]         h_cnt_next;
  logic               h_vld;
  logic [2:0]         h_face [2];
  logic [FW-1:0]      h_t [2];
  logic [1:0]         h_cnt;
  logic signed [19:0] h_org [3];
  logic signed [19:0] h_spn [3];

  always_comb begin
    logic cv;
    logic fv;
    cv         = 1'b0;
    fv         = 1'b0;
    h_c_next   = '0;
    h_f_next   = '0;
    h_ct_next  = '0;
    h_ft_next  = '0;
    for (int i = 0; i < NF; i++) begin
      if (g_hit[i] && (!fv || g_fr[i] <= h_ft_next)) begin
        if (!cv || g_fr[i] <= h_ct_next) begin
          h_f_next  = h_c_next;
          h_ft_next = h_ct_next;
          fv        = cv;
          h_c_next  = 3'(i);
          h_ct_next = g_fr[i];
          cv        = 1'b1;
        end else begin
          h_f_next  = 3'(i);
          h_ft_next = g_fr[i];
          fv        = 1'b1;
        end
      end
    end
    h_cnt_next = {1'b0, cv} + {1'b0, fv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (en) begin
      h_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_face[0] <= h_c_next;
      h_face[1] <= h_f_next;
      h_t[0]    <= h_ct_next;
      h_t[1]    <= h_ft_next;
      h_cnt     <= h_cnt_next;
      h_org     <= g_org;
      h_spn     <= g_spn;
    end
  end

  // Stage I: normals and span products for the picked crossings
  logic signed [15:0] i_nrm_next [2][3];
  logic               i_vld;
  logic signed [15:0] i_nrm [2][3];
  logic signed [37:0] i_ht [2][3];
  logic signed [37:0] i_sd [2][3];
  logic [2:0]         i_face [2];
  logic [FW-1:0]      i_t [2];
  logic [1:0]         i_cnt;
  logic signed [19:0] i_org [3];

  always_comb begin
    logic [1:0] ax;
    for (int r = 0; r < 2; r++) begin
      ax = (h_face[r] >= 3'd3) ? 2'(h_face[r] - 3'd3) : 2'(h_face[r]);
      for (int k = 0; k < 3; k++) begin
        i_nrm_next[r][k] = (h_face[r] >= 3'd3) ? rbfh_pkg::neg_axis(nm[ax][k])
                                                : nm[ax][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
    end else if (en) begin
      i_vld <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 2; r++) begin
        for (int k = 0; k < 3; k++) begin
          i_ht[r][k] <= 38'(h_spn[k]) * 38'($signed({1'b0, h_t[r]}));
          i_sd[r][k] <= 38'(h_spn[k])
                      * 38'($signed({1'b0, h_t[r]}) - $signed(18'd65536));
        end
      end
      i_nrm  <= i_nrm_next;
      i_face <= h_face;
      i_t    <= h_t;
      i_cnt  <= h_cnt;
      i_org  <= h_org;
    end
  end

  // Stage J: world location and depth products
  logic               j_vld;
  logic signed [19:0] j_hit [2][3];
  logic signed [53:0] j_dp [2][3];
  logic signed [15:0] j_nrm [2][3];
  logic [2:0]         j_face [2];
  logic [FW-1:0]      j_t [2];
  logic [1:0]         j_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_vld <= 1'b0;
    end else if (en) begin
      j_vld <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [38:0] w;
    if (en) begin
      for (int r = 0; r < 2; r++) begin
        for (int k = 0; k < 3; k++) begin
          w = 39'($signed({i_org[k], {rbfh_pkg::FRAC_BITS{1'b0}}})) + 39'(i_ht[r][k])
            + 39'sd32768;
          j_hit[r][k] <= rbfh_pkg::sat_coord(40'(w >>> rbfh_pkg::FRAC_BITS));
          j_dp[r][k]  <= 54'(i_nrm[r][k]) * 54'(i_sd[r][k]);
        end
      end
      j_nrm  <= i_nrm;
      j_face <= i_face;
      j_t    <= i_t;
      j_cnt  <= i_cnt;
    end
  end

  // Stage K: depth rounding and result records
  rbfh_pkg::result_t k_rec_next [2];
  rbfh_pkg::result_t k_rec [2];

  always_comb begin
    logic signed [55:0] dsum;
    for (int r = 0; r < 2; r++) begin
      dsum = 56'(j_dp[r][0]) + 56'(j_dp[r][1]) + 56'(j_dp[r][2]) + 56'sd536870912;
      k_rec_next[r].hit_valid   = 1'b1;
      k_rec_next[r].face_index  = j_face[r];
      k_rec_next[r].fraction    = j_t[r];
      k_rec_next[r].hit_x       = j_hit[r][0];
      k_rec_next[r].hit_y       = j_hit[r][1];
      k_rec_next[r].hit_z       = j_hit[r][2];
      k_rec_next[r].normal_x    = j_nrm[r][0];
      k_rec_next[r].normal_y    = j_nrm[r][1];
      k_rec_next[r].normal_z    = j_nrm[r][2];
      k_rec_next[r].pen_depth   = rbfh_pkg::sat_coord(
        40'(dsum >>> (rbfh_pkg::FRAC_BITS + rbfh_pkg::AXIS_FRAC_BITS)));
      k_rec_next[r].last_result = (j_cnt == 2'(r + 1));
    end
    // Miss: a single empty record
    if (j_cnt == 2'd0) begin
      k_rec_next[0]             = '0;
      k_rec_next[0].last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (en) begin
        k_vld <= j_vld;
      end
      phase <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_rec <= k_rec_next;
      k_two <= (j_cnt == 2'd2);
    end
  end

  // Result port
  assign result_valid = k_vld;
  assign result       = phase ? k_rec[1] : k_rec[0];

endmodule

[rtl/core/rbfh_check.sv]
// Port-level checker for the face crossing core, bound to the top level.
module rbfh_check (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              result_valid,
  input rbfh_pkg::result_t result
);

  // Busy only while the first of two results is shown
  a_busy_first: assert property (@(posedge clk) disable iff (rst)
    busy |-> (result_valid && result.hit_valid && !result.last_result))
    else $error("busy without a pending first result");

  // The second result follows right after
  a_second: assert property (@(posedge clk) disable iff (rst)
    busy |=> (result_valid && result.hit_valid && result.last_result))
    else $error("second result missing");

  // A miss is always the only result
  a_miss: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.hit_valid) |-> (result.last_result && !busy))
    else $error("miss not final");

  // Crossing fields stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.hit_valid) |->
      (result.face_index <= 3'd5 && result.fraction <= 17'd65536))
    else $error("crossing field out of range");

endmodule

bind ray_box_face_hits_core rbfh_check u_rbfh_check (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

[bench/ray_box_face_hits_core_test.sv]
// Self-checking bench for ray_box_face_hits_core: face crossings predicted and compared per item.
module ray_box_face_hits_core_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_W = $bits(rbfh_pkg::item_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  rbfh_pkg::item_t item = '0;
  logic result_valid;
  rbfh_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rbfh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rbfh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the box registers
  logic [47:0] axis_rows [3];
  logic [59:0] box_ctr;
  logic [59:0] box_ext;

  rbfh_pkg::item_t segments_q [$];
  rbfh_pkg::result_t hits_due_q [$];
  int idle_pct = 0;
  int errors = 0;
  int cycles = 0;
  int items_taken = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int misses_seen = 0;

  ray_box_face_hits_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic signed [rbfh_pkg::COORD_W-1:0] clamp_coord(input longint v);
    if (v > 524287) begin
      return 20'sd524287;
    end else if (v < -524288) begin
      return -20'sd524288;
    end
    return rbfh_pkg::COORD_W'(v);
  endfunction

  // Expected crossings of one segment, queued in output order
  task automatic predict_face_hits(input rbfh_pkg::item_t it);
    longint nv [3][3];
    longint org [3];
    longint spn [3];
    longint pos [3];
    longint ext [3];
    longint fr [6];
    longint dv, proj, num, e, loc, lcl, t, depth, w;
    longint nrm [3];
    bit in_box;
    int near_f, far_f, cnt, f, a;
    int pick [2];
    rbfh_pkg::result_t r;
    near_f = -1;
    far_f = -1;
    org[0] = longint'(it.origin_x);
    org[1] = longint'(it.origin_y);
    org[2] = longint'(it.origin_z);
    spn[0] = longint'(it.span_x);
    spn[1] = longint'(it.span_y);
    spn[2] = longint'(it.span_z);
    for (int ax = 0; ax < 3; ax++) begin
      for (int k = 0; k < 3; k++) begin
        nv[ax][k] = longint'($signed(axis_rows[ax][16*k +: 16]));
      end
      ext[ax] = longint'(box_ext[20*ax +: 20]);
      pos[ax] = org[ax] - longint'($signed(box_ctr[20*ax +: 20]));
    end
    for (int i = 0; i < 6; i++) begin
      a = i % 3;
      fr[i] = -1;
      dv = 0;
      proj = 0;
      for (int k = 0; k < 3; k++) begin
        dv += nv[a][k] * spn[k];
        proj += nv[a][k] * pos[k];
      end
      e = ext[a] <<< rbfh_pkg::AXIS_FRAC_BITS;
      num = (i < 3 ? e : -e) - proj;
      if (dv == 0) continue;
      if (dv < 0) begin
        dv = -dv;
        num = -num;
      end
      if (num < 0 || num > dv) continue;
      fr[i] = (num * 65536) / dv;
      in_box = 1'b1;
      for (int ax = 0; ax < 3; ax++) begin
        lcl = 0;
        for (int k = 0; k < 3; k++) begin
          loc = pos[k] * 65536 + spn[k] * fr[i];
          lcl += nv[ax][k] * loc;
        end
        if (lcl < 0) lcl = -lcl;
        if (ext[ax] == 0 || lcl * 100 > (ext[ax] <<< 30) * 101) in_box = 1'b0;
      end
      if (!in_box) continue;
      // keep the two nearest; later face wins a tie
      if (far_f < 0 || fr[i] <= fr[far_f]) begin
        if (near_f < 0 || fr[i] <= fr[near_f]) begin
          far_f = near_f;
          near_f = i;
        end else begin
          far_f = i;
        end
      end
    end
    if (near_f < 0) begin
      r = '0;
      r.last_result = 1'b1;
      hits_due_q = {hits_due_q, r};
      return;
    end
    pick[0] = near_f;
    pick[1] = far_f;
    cnt = (far_f >= 0) ? 2 : 1;
    for (int n = 0; n < cnt; n++) begin
      f = pick[n];
      a = f % 3;
      t = fr[f];
      depth = 0;
      for (int k = 0; k < 3; k++) begin
        if (f > 2) nrm[k] = (nv[a][k] == -32768) ? 32767 : -nv[a][k];
        else nrm[k] = nv[a][k];
        depth += nrm[k] * (spn[k] * (t - 65536));
      end
      r.hit_valid = 1'b1;
      r.face_index = 3'(f);
      r.fraction = rbfh_pkg::FRAC_W'(t);
      w = (org[0] * 65536 + spn[0] * t + 32768) >>> 16;
      r.hit_x = clamp_coord(w);
      w = (org[1] * 65536 + spn[1] * t + 32768) >>> 16;
      r.hit_y = clamp_coord(w);
      w = (org[2] * 65536 + spn[2] * t + 32768) >>> 16;
      r.hit_z = clamp_coord(w);
      r.normal_x = rbfh_pkg::AXIS_W'(nrm[0]);
      r.normal_y = rbfh_pkg::AXIS_W'(nrm[1]);
      r.normal_z = rbfh_pkg::AXIS_W'(nrm[2]);
      r.pen_depth = clamp_coord((depth + (longint'(1) <<< 29)) >>> 30);
      r.last_result = (n == cnt - 1);
      hits_due_q = {hits_due_q, r};
    end
  endtask

  task automatic report_mismatch(input string fname, input longint got, input longint want);
    errors++;
    $display("mismatch on result %0d, %s: got %0d, expected %0d", results_seen, fname, got, want);
  endtask

  // Driver: take the next pending item unless idling; hold while busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_face_hits(item);
        items_taken++;
      end
      if (!(start && busy)) begin
        if (segments_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          item <= segments_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result against the oldest expectation
  always @(posedge clk) begin
    rbfh_pkg::result_t exp_r;
    if (!rst && result_valid) begin
      results_seen++;
      if (result.hit_valid) hits_seen++;
      else misses_seen++;
      if (hits_due_q.size() == 0) begin
        errors++;
        $display("unexpected result %0d with nothing pending", results_seen);
      end else begin
        exp_r = hits_due_q.pop_front();
        if (result.hit_valid !== exp_r.hit_valid)
          report_mismatch("hit_valid", longint'(result.hit_valid), longint'(exp_r.hit_valid));
        if (result.face_index !== exp_r.face_index)
          report_mismatch("face_index", longint'(result.face_index),
                          longint'(exp_r.face_index));
        if (result.fraction !== exp_r.fraction)
          report_mismatch("fraction", longint'(result.fraction), longint'(exp_r.fraction));
        if (result.hit_x !== exp_r.hit_x)
          report_mismatch("hit_x", longint'(result.hit_x), longint'(exp_r.hit_x));
        if (result.hit_y !== exp_r.hit_y)
          report_mismatch("hit_y", longint'(result.hit_y), longint'(exp_r.hit_y));
        if (result.hit_z !== exp_r.hit_z)
          report_mismatch("hit_z", longint'(result.hit_z), longint'(exp_r.hit_z));
        if (result.normal_x !== exp_r.normal_x)
          report_mismatch("normal_x", longint'(result.normal_x), longint'(exp_r.normal_x));
        if (result.normal_y !== exp_r.normal_y)
          report_mismatch("normal_y", longint'(result.normal_y), longint'(exp_r.normal_y));
        if (result.normal_z !== exp_r.normal_z)
          report_mismatch("normal_z", longint'(result.normal_z), longint'(exp_r.normal_z));
        if (result.pen_depth !== exp_r.pen_depth)
          report_mismatch("pen_depth", longint'(result.pen_depth), longint'(exp_r.pen_depth));
        if (result.last_result !== exp_r.last_result)
          report_mismatch("last_result", longint'(result.last_result),
                          longint'(exp_r.last_result));
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] pack_axis(input int x, input int y, input int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [59:0] pack_coord(input int x, input int y, input int z);
    return {20'(z), 20'(y), 20'(x)};
  endfunction

  // Register write over the config channel; mirror it on acceptance
  task automatic write_reg(input rbfh_pkg::cfg_idx_t idx, input logic [59:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rbfh_pkg::CFG_AXIS_X: axis_rows[0] = val[47:0];
      rbfh_pkg::CFG_AXIS_Y: axis_rows[1] = val[47:0];
      rbfh_pkg::CFG_AXIS_Z: axis_rows[2] = val[47:0];
      rbfh_pkg::CFG_CENTER: box_ctr = val;
      rbfh_pkg::CFG_EXTENTS: box_ext = val;
      default: ;
    endcase
  endtask

  task automatic set_box(input logic [47:0] rx, input logic [47:0] ry, input logic [47:0] rz,
                         input logic [59:0] ctr, input logic [59:0] ext);
    write_reg(rbfh_pkg::CFG_AXIS_X, {12'b0, rx});
    write_reg(rbfh_pkg::CFG_AXIS_Y, {12'b0, ry});
    write_reg(rbfh_pkg::CFG_AXIS_Z, {12'b0, rz});
    write_reg(rbfh_pkg::CFG_CENTER, ctr);
    write_reg(rbfh_pkg::CFG_EXTENTS, ext);
  endtask

  task automatic add_seg(input int ox, input int oy, input int oz,
                         input int sx, input int sy, input int sz);
    rbfh_pkg::item_t it;
    it.origin_x = rbfh_pkg::COORD_W'(ox);
    it.origin_y = rbfh_pkg::COORD_W'(oy);
    it.origin_z = rbfh_pkg::COORD_W'(oz);
    it.span_x = rbfh_pkg::COORD_W'(sx);
    it.span_y = rbfh_pkg::COORD_W'(sy);
    it.span_z = rbfh_pkg::COORD_W'(sz);
    segments_q = {segments_q, it};
  endtask

  // Mostly segments aimed through the box, some raw noise
  task automatic add_random_seg();
    int tg [3];
    int og [3];
    int sp [3];
    int reach;
    rbfh_pkg::item_t it;
    if ($urandom_range(99) < 20) begin
      it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
      segments_q = {segments_q, it};
      return;
    end
    reach = 1 << $urandom_range(6, 13);
    for (int k = 0; k < 3; k++) begin
      tg[k] = int'($signed(box_ctr[20*k +: 20])) + $urandom_range(0, 2 * reach) - reach;
      og[k] = tg[k] + $urandom_range(0, 4 * reach) - 2 * reach;
      sp[k] = (tg[k] - og[k]) * $urandom_range(1, 3) + $urandom_range(0, 8) - 4;
      if ($urandom_range(99) < 12) sp[k] = 0;
    end
    add_seg(og[0], og[1], og[2], sp[0], sp[1], sp[2]);
  endtask

  task automatic drain();
    while (segments_q.size() > 0 || start || hits_due_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int per_phase;
    axis_rows[0] = 48'd16384;
    axis_rows[1] = 48'd16384 << 16;
    axis_rows[2] = 48'd16384 << 32;
    box_ctr = '0;
    box_ext = pack_coord(1024, 1024, 1024);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed segments against the reset box (unit cube, half size 1.0)
    idle_pct = 23;
    add_seg(0, 0, 0, 0, 0, 0);                     // zero span: every face skipped
    add_seg(-2048, 0, 0, 4096, 0, 0);              // straight through, two crossings
    add_seg(1024, 0, 0, 1024, 0, 0);               // starts on a face
    add_seg(-2048, 0, 0, 1024, 0, 0);              // ends on a face
    add_seg(-2048, -2048, 0, 4096, 4096, 0);       // through an edge, tied fractions
    add_seg(-2048, -2048, -2048, 4096, 4096, 4096); // through a corner
    add_seg(-2048, 1024, 0, 4096, 0, 0);           // grazing along a face
    add_seg(-2048, 1034, 0, 4096, 0, 0);           // just within tolerance
    add_seg(-2048, 1035, 0, 4096, 0, 0);           // just outside tolerance
    add_seg(0, 0, 0, 512, 0, 0);                   // inside, never reaches a face
    add_seg(0, 0, 0, 0, 0, -4096);                 // from inside out through a minus face
    add_seg(5000, 5000, 5000, 100, 0, 0);          // clean miss
    add_seg(524287, 524287, 524287, -524288, -524288, -524288);
    add_seg(-524288, -524288, -524288, 524287, 524287, 524287);
    add_seg(0, 0, 0, 524287, 524287, 524287);
    add_seg(-524288, 0, 0, 524287, 0, 0);
    add_seg(524287, -1, 0, -524288, 1, 3);
    add_seg(-1, -1, -1, 3, 3, 3);
    drain();

    per_phase = 1750 / 6;
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 23 : (ph < 4) ? 72 : 0;
      case (ph)
        0: set_box(pack_axis(11585, 11585, 0), pack_axis(-11585, 11585, 0),
                   pack_axis(0, 0, 16384), pack_coord(3000, -2000, 500),
                   pack_coord(2048, 512, 1536));
        1: set_box(pack_axis(-32768, 0, 0), pack_axis(0, -16384, 0),
                   pack_axis(0, 0, 32767), pack_coord(0, 0, 0),
                   pack_coord(1024, 1024, 1024));
        2: set_box(pack_axis(16384, 0, 0), pack_axis(0, 16384, 0), pack_axis(0, 0, 16384),
                   pack_coord(524287, -524288, 0), pack_coord(0, 1024, 2048));
        3: set_box(pack_axis(16384, 0, 0), pack_axis(0, 16384, 0), pack_axis(0, 0, 16384),
                   pack_coord(0, 0, 0), pack_coord(1048575, 1048575, 1048575));
        4: set_box(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                   48'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                   60'({$urandom, $urandom}));
        default: set_box(pack_axis(16384, 0, 0), pack_axis(0, 16384, 0),
                         pack_axis(0, 0, 16384), pack_coord(0, 0, 0),
                         pack_coord(1024, 1024, 1024));
      endcase
      for (int n = 0; n < per_phase; n++) add_random_seg();
      drain();
    end

    $display("covered %0d segments over 7 box setups, %0d results (%0d crossings, %0d misses)",
             items_taken, results_seen, hits_seen, misses_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
